// File: sv/fdsa_pkg.sv
// shared constants, command codes and helper functions for the data stack unit
package fdsa_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 5;
    localparam int DEPTH_W         = 7;
    localparam int ERR_W           = 3;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_CELL_COUNT  = 256;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [ERR_W-1:0]  err_t;

    localparam cmd_t CMD_PUSH   = 5'd0;
    localparam cmd_t CMD_ADD    = 5'd1;
    localparam cmd_t CMD_SUB    = 5'd2;
    localparam cmd_t CMD_MUL    = 5'd3;
    localparam cmd_t CMD_DIV    = 5'd4;
    localparam cmd_t CMD_MOD    = 5'd5;
    localparam cmd_t CMD_DIVMOD = 5'd6;
    localparam cmd_t CMD_NEGATE = 5'd7;
    localparam cmd_t CMD_INVERT = 5'd8;
    localparam cmd_t CMD_AND    = 5'd9;
    localparam cmd_t CMD_DROP   = 5'd10;
    localparam cmd_t CMD_2DROP  = 5'd11;
    localparam cmd_t CMD_DUP    = 5'd12;
    localparam cmd_t CMD_OVER   = 5'd13;
    localparam cmd_t CMD_SWAP   = 5'd14;
    localparam cmd_t CMD_ROT    = 5'd15;
    localparam cmd_t CMD_MAX    = 5'd16;
    localparam cmd_t CMD_MIN    = 5'd17;
    localparam cmd_t CMD_LESS   = 5'd18;
    localparam cmd_t CMD_STORE  = 5'd19;
    localparam cmd_t CMD_FETCH  = 5'd20;
    localparam cmd_t CMD_NOT    = 5'd21;

    localparam err_t ERR_OK    = 3'd0;
    localparam err_t ERR_UNDER = 3'd1;
    localparam err_t ERR_OVER  = 3'd2;
    localparam err_t ERR_DIVZ  = 3'd3;
    localparam err_t ERR_ADDR  = 3'd4;

    // entries consumed
    function automatic logic [1:0] cmd_need(input cmd_t c);
        logic [1:0] n;
        case (c)
            CMD_PUSH:                                  n = 2'd0;
            CMD_NEGATE, CMD_INVERT, CMD_DROP, CMD_DUP,
            CMD_FETCH, CMD_NOT:                        n = 2'd1;
            CMD_ROT:                                   n = 2'd3;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_DIVMOD,
            CMD_AND, CMD_2DROP, CMD_OVER, CMD_SWAP, CMD_MAX, CMD_MIN,
            CMD_LESS, CMD_STORE:                       n = 2'd2;
            default:                                   n = 2'd0;
        endcase
        return n;
    endfunction

    // entries produced
    function automatic logic [1:0] cmd_make(input cmd_t c);
        logic [1:0] m;
        case (c)
            CMD_DROP, CMD_2DROP, CMD_STORE:            m = 2'd0;
            CMD_DIVMOD, CMD_DUP, CMD_SWAP:             m = 2'd2;
            CMD_OVER, CMD_ROT:                         m = 2'd3;
            CMD_PUSH, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD,
            CMD_NEGATE, CMD_INVERT, CMD_AND, CMD_MAX, CMD_MIN,
            CMD_LESS, CMD_FETCH, CMD_NOT:              m = 2'd1;
            default:                                   m = 2'd0;
        endcase
        return m;
    endfunction

endpackage

// File: sv/fdsa_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
module fdsa_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fdsa_pkg::word_t      dividend,
    input  fdsa_pkg::word_t      divisor,
    output logic                 done,
    output fdsa_pkg::word_t      quotient,
    output fdsa_pkg::word_t      remainder
);
    import fdsa_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    word_t             num_reg, num_next;
    word_t             den_reg, den_next;
    logic [DATA_W:0]   rem_reg, rem_next;
    logic              qneg_reg, qneg_next;
    logic              rneg_reg, rneg_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   shifted;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        shifted   = {rem_reg[DATA_W-1:0], num_reg[DATA_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            num_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            rem_next  = '0;
            qneg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rneg_next = dividend[DATA_W-1];
        end
        else if (run_reg)
        begin
            // restoring step, quotient bits shift into the numerator register
            if (!trial[DATA_W])
            begin
                rem_next = trial;
                num_next = {num_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                num_next = {num_reg[DATA_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? (~num_reg + 1'b1) : num_reg;
    assign remainder = rneg_reg ? (~rem_reg[DATA_W-1:0] + 1'b1) : rem_reg[DATA_W-1:0];

endmodule

// File: sv/fdsa_stack_mem.sv
// deep stack storage below the two cached entries, one write and two read ports
module fdsa_stack_mem #(
    parameter int STACK_DEPTH = fdsa_pkg::DEF_STACK_DEPTH
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
    input  fdsa_pkg::word_t                wdata,
    input  logic [$clog2(STACK_DEPTH)-1:0] raddr0,
    input  logic [$clog2(STACK_DEPTH)-1:0] raddr1,
    output fdsa_pkg::word_t                rdata0,
    output fdsa_pkg::word_t                rdata1
);
    import fdsa_pkg::*;

    word_t mem [STACK_DEPTH];
    word_t rd0_reg;
    word_t rd1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

// File: sv/fdsa_cell_mem.sv
// variable cell storage, single port with registered read
module fdsa_cell_mem #(
    parameter int CELL_COUNT = fdsa_pkg::DEF_CELL_COUNT,
    parameter int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  fdsa_pkg::word_t   wdata,
    output fdsa_pkg::word_t   rdata
);
    import fdsa_pkg::*;

    word_t mem [CELL_COUNT];
    word_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_reg <= mem[addr];
    end

    assign rdata = rd_reg;

endmodule

// File: sv/forth_data_stack_alu.sv
// data stack unit: two cached top entries, deep stack and variable cells in memory
// stack and arithmetic commands complete from the execute state; fetch adds a cell read state,
//   and div, mod and divmod wait in the divide state for the divider (one quotient bit per cycle)
// a new command is taken only in idle, so the unit cannot accept one before the last is done
// after reset the variable cells are zeroed, one per cycle; busy stays high until the last is cleared
// done marks each result for exactly one cycle; the receiver cannot stall
module forth_data_stack_alu #(
    parameter int STACK_DEPTH = fdsa_pkg::DEF_STACK_DEPTH,
    parameter int CELL_COUNT  = fdsa_pkg::DEF_CELL_COUNT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fdsa_pkg::cmd_t                    command,
    input  logic signed [fdsa_pkg::DATA_W-1:0] literal,
    output logic                              done,
    output logic signed [fdsa_pkg::DATA_W-1:0] top_value,
    output logic signed [fdsa_pkg::DATA_W-1:0] second_value,
    output logic [fdsa_pkg::DEPTH_W-1:0]      depth,
    output fdsa_pkg::err_t                    error_code
);
    import fdsa_pkg::*;

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          done_reg, done_next;
    err_t          err_reg, err_next;
    word_t         top_reg, top_next;
    word_t         sec_reg, sec_next;
    cmd_t          cmd_reg, cmd_next;
    word_t         lit_reg, lit_next;

    logic          smem_we;
    logic [SW-1:0] smem_waddr;
    word_t         smem_wdata;
    word_t         smem_rd0, smem_rd1;
    logic [CW-1:0] cnt_m2, cnt_m3, cnt_m4;

    logic          cmem_we;
    logic [AW-1:0] cmem_addr;
    word_t         cmem_wdata;
    word_t         cmem_rdata;

    logic          div_start, div_done;
    word_t         div_quo, div_rem;

    logic [1:0]    need, make;
    logic [CW:0]   cnt_x, cnt_after;
    logic          underflow, overflow, addr_bad, is_divop;
    word_t         alu_res, deep0, deep1, res_p, res_q;
    logic          commit;
    logic signed [DATA_W-1:0] sa, sb;
    word_t         prod;

    assign cnt_m2 = count_reg - CW'(2);
    assign cnt_m3 = count_reg - CW'(3);
    assign cnt_m4 = count_reg - CW'(4);

    fdsa_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_mem (
        .clk    (clk),
        .we     (smem_we),
        .waddr  (smem_waddr),
        .wdata  (smem_wdata),
        .raddr0 (cnt_m3[SW-1:0]),
        .raddr1 (cnt_m4[SW-1:0]),
        .rdata0 (smem_rd0),
        .rdata1 (smem_rd1)
    );

    fdsa_cell_mem #(
        .CELL_COUNT (CELL_COUNT),
        .ADDR_W     (AW)
    ) u_cell_mem (
        .clk   (clk),
        .we    (cmem_we),
        .addr  (cmem_addr),
        .wdata (cmem_wdata),
        .rdata (cmem_rdata)
    );

    fdsa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (sec_reg),
        .divisor   (top_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign need      = cmd_need(cmd_reg);
    assign make      = cmd_make(cmd_reg);
    assign cnt_x     = {1'b0, count_reg};
    assign underflow = cnt_x < (CW+1)'(need);
    assign cnt_after = cnt_x - (CW+1)'(need) + (CW+1)'(make);
    assign overflow  = cnt_after > (CW+1)'(STACK_DEPTH);
    assign addr_bad  = top_reg[DATA_W-1] || (top_reg >= DATA_W'(CELL_COUNT));
    assign is_divop  = (cmd_reg == CMD_DIV) || (cmd_reg == CMD_MOD) || (cmd_reg == CMD_DIVMOD);
    assign deep0     = (count_reg >= CW'(3)) ? smem_rd0 : '0;
    assign deep1     = (count_reg >= CW'(4)) ? smem_rd1 : '0;
    assign sa        = top_reg;
    assign sb        = sec_reg;
    assign prod      = sec_reg * top_reg;

    always_comb
    begin
        case (cmd_reg)
            CMD_ADD:    alu_res = sec_reg + top_reg;
            CMD_SUB:    alu_res = sec_reg - top_reg;
            CMD_MUL:    alu_res = prod;
            CMD_NEGATE: alu_res = '0 - top_reg;
            CMD_INVERT: alu_res = ~top_reg;
            CMD_AND:    alu_res = sec_reg & top_reg;
            CMD_MAX:    alu_res = (sb > sa) ? sec_reg : top_reg;
            CMD_MIN:    alu_res = (sb < sa) ? sec_reg : top_reg;
            CMD_LESS:   alu_res = (sb < sa) ? '1 : '0;
            CMD_NOT:    alu_res = (top_reg == '0) ? '1 : '0;
            default:    alu_res = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        err_next   = err_reg;
        top_next   = top_reg;
        sec_next   = sec_reg;
        cmd_next   = cmd_reg;
        lit_next   = lit_reg;
        smem_we    = 1'b0;
        smem_waddr = cnt_m2[SW-1:0];
        smem_wdata = sec_reg;
        cmem_we    = 1'b0;
        cmem_addr  = top_reg[AW-1:0];
        cmem_wdata = sec_reg;
        div_start  = 1'b0;
        commit     = 1'b0;
        res_p      = alu_res;
        res_q      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmem_we    = 1'b1;
                cmem_addr  = clr_reg;
                cmem_wdata = '0;
                if (clr_reg == AW'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    lit_next   = literal;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // priority: unknown commands complete with no error, then underflow, overflow, then operand checks
                priority if (cmd_reg > CMD_NOT)
                begin
                    done_next  = 1'b1;
                    err_next   = ERR_OK;
                    state_next = S_IDLE;
                end
                else if (underflow)
                begin
                    done_next  = 1'b1;
                    err_next   = ERR_UNDER;
                    state_next = S_IDLE;
                end
                else if (overflow)
                begin
                    done_next  = 1'b1;
                    err_next   = ERR_OVER;
                    state_next = S_IDLE;
                end
                else if (is_divop && top_reg == '0)
                begin
                    done_next  = 1'b1;
                    err_next   = ERR_DIVZ;
                    state_next = S_IDLE;
                end
                else if ((cmd_reg == CMD_STORE || cmd_reg == CMD_FETCH) && addr_bad)
                begin
                    done_next  = 1'b1;
                    err_next   = ERR_ADDR;
                    state_next = S_IDLE;
                end
                else if (is_divop)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (cmd_reg == CMD_FETCH)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    if (cmd_reg == CMD_STORE)
                    begin
                        cmem_we = 1'b1;
                    end
                    commit = 1'b1;
                end
            end
            S_DIV:
            begin
                res_p = (cmd_reg == CMD_DIV) ? div_quo : div_rem;
                res_q = div_quo;
                if (div_done)
                begin
                    commit = 1'b1;
                end
            end
            S_FETCH:
            begin
                res_p  = cmem_rdata;
                commit = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit)
        begin
            done_next  = 1'b1;
            err_next   = ERR_OK;
            state_next = S_IDLE;
            count_next = cnt_after[CW-1:0];
            case (cmd_reg)
                CMD_PUSH, CMD_DUP, CMD_OVER:
                begin
                    // old second spills into the deep store
                    smem_we = (count_reg >= CW'(2));
                    if (cmd_reg == CMD_PUSH)
                    begin
                        top_next = lit_reg;
                        sec_next = top_reg;
                    end
                    else if (cmd_reg == CMD_DUP)
                    begin
                        sec_next = top_reg;
                    end
                    else
                    begin
                        top_next = sec_reg;
                        sec_next = top_reg;
                    end
                end
                CMD_SWAP:
                begin
                    top_next = sec_reg;
                    sec_next = top_reg;
                end
                CMD_ROT:
                begin
                    smem_we    = 1'b1;
                    smem_waddr = cnt_m3[SW-1:0];
                    top_next   = deep0;
                    sec_next   = top_reg;
                end
                CMD_DIVMOD:
                begin
                    top_next = res_q;
                    sec_next = res_p;
                end
                CMD_NEGATE, CMD_INVERT, CMD_NOT, CMD_FETCH:
                begin
                    top_next = res_p;
                end
                CMD_DROP:
                begin
                    top_next = sec_reg;
                    sec_next = deep0;
                end
                CMD_2DROP, CMD_STORE:
                begin
                    top_next = deep0;
                    sec_next = deep1;
                end
                default:
                begin
                    top_next = res_p;
                    sec_next = deep0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            count_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            err_reg   <= ERR_OK;
            top_reg   <= '0;
            sec_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
            top_reg   <= top_next;
            sec_reg   <= sec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        lit_reg <= lit_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign top_value    = top_reg;
    assign second_value = sec_reg;
    assign depth        = DEPTH_W'(count_reg);
    assign error_code   = err_reg;

endmodule
